// ----- sv/tlbpt_pkg.sv -----
// Shared constants, types and the page number reduction table for the TLB translator.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package tlbpt_pkg;

   localparam int TLB_ENTRIES  = 16;
   localparam int PAGE_COUNT   = 256;

   localparam int ADDR_W       = 16;
   localparam int OFFSET_W     = 8;
   localparam int PAGE_IN_W    = ADDR_W - OFFSET_W;
   localparam int FRAME_W      = 8;
   localparam int NEXT_FRAME_W = 9;
   localparam int PAGE_W       = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
   localparam int FILL_W       = $clog2(TLB_ENTRIES + 1);

   typedef logic [PAGE_W-1:0] page_map_type [2**PAGE_IN_W];

   // Reduces each raw page number modulo the page table size. This is evaluated
   // once at elaboration and becomes a constant lookup table.
   function automatic page_map_type build_page_map();
      page_map_type m;
      for (int i = 0; i < 2**PAGE_IN_W; i++) begin
         m[i] = PAGE_W'(i % PAGE_COUNT);
      end
      return m;
   endfunction

   localparam page_map_type PAGE_MAP = build_page_map();

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_req;
      logic lookup;
      logic commit;
   } tlbpt_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic rsp_free;
   } tlbpt_status_type;

endpackage

`default_nettype wire

// ----- sv/tlbpt_ctrl.sv -----
// Sequencing state machine for the TLB translator: accept, lookup, commit.
// Depends on tlbpt_pkg for the command and status structs.
`default_nettype none

module tlbpt_ctrl
   import tlbpt_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire tlbpt_status_type status,
   output tlbpt_cmd_type         cmd
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_LOOKUP = 2'd1;
   localparam logic [1:0] S_UPDATE = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = S_UPDATE;
         end
         S_UPDATE: begin
            // The commit waits until the result register can take the beat.
            if (status.rsp_free) begin
               cmd.commit = 1'b1;
               req_ready  = 1'b1;
               if (req_valid) begin
                  cmd.load_req = 1'b1;
                  state_in     = S_LOOKUP;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ----- sv/tlbpt_dp.sv -----
// Datapath of the TLB translator: request register, TLB, page table, frame
// allocator and result register. Depends on tlbpt_pkg.
`default_nettype none

module tlbpt_dp
   import tlbpt_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire tlbpt_cmd_type       cmd,
   output tlbpt_status_type         status,
   input  wire logic [ADDR_W-1:0]   req_logical_address,
   input  wire logic                rsp_ready,
   output logic                     rsp_valid,
   output logic [ADDR_W-1:0]        rsp_phys_addr,
   output logic                     rsp_tlb_hit,
   output logic                     rsp_page_fault
);

   // Request register.
   logic [PAGE_W-1:0]   page_ff;
   logic [OFFSET_W-1:0] offset_ff;

   // TLB.
   logic [PAGE_W-1:0]      tlb_page_ff  [TLB_ENTRIES];
   logic [FRAME_W-1:0]     tlb_frame_ff [TLB_ENTRIES];
   logic [TLB_ENTRIES-1:0] tlb_valid_ff;
   logic [FILL_W-1:0]      tlb_fill_ff;
   logic                   tlb_full;

   // Page table.
   logic [FRAME_W-1:0]    page_frame_ff [PAGE_COUNT];
   logic [PAGE_COUNT-1:0] page_valid_ff;
   logic [NEXT_FRAME_W-1:0] next_frame_ff;

   // Lookup results.
   logic               hit_in;
   logic [FRAME_W-1:0] hit_frame_in;
   logic               hit_ff;
   logic [FRAME_W-1:0] hit_frame_ff;
   logic               pg_valid_ff;
   logic [FRAME_W-1:0] rd_frame_ff;

   // Commit values.
   logic               fault;
   logic               miss;
   logic [FRAME_W-1:0] frame_sel;

   // Result register.
   logic                rsp_valid_ff;
   logic [ADDR_W-1:0]   rsp_addr_ff;
   logic                rsp_hit_ff;
   logic                rsp_fault_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         page_ff   <= PAGE_MAP[req_logical_address[ADDR_W-1:OFFSET_W]];
         offset_ff <= req_logical_address[OFFSET_W-1:0];
      end
   end

   // Fully associative compare; the lowest matching slot wins.
   always_comb begin
      hit_in       = 1'b0;
      hit_frame_in = '0;
      for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
         if (tlb_valid_ff[i] && (tlb_page_ff[i] == page_ff)) begin
            hit_in       = 1'b1;
            hit_frame_in = tlb_frame_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         hit_ff       <= hit_in;
         hit_frame_ff <= hit_frame_in;
         pg_valid_ff  <= page_valid_ff[page_ff];
      end
   end

   assign miss      = !hit_ff;
   assign fault     = !hit_ff && !pg_valid_ff;
   assign frame_sel = hit_ff      ? hit_frame_ff :
                      pg_valid_ff ? rd_frame_ff  : next_frame_ff[FRAME_W-1:0];
   assign tlb_full  = (tlb_fill_ff == FILL_W'(TLB_ENTRIES));

   // Page table frame memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.commit && fault) begin
         page_frame_ff[page_ff] <= next_frame_ff[FRAME_W-1:0];
      end
      if (cmd.lookup) begin
         rd_frame_ff <= page_frame_ff[page_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         page_valid_ff <= '0;
         next_frame_ff <= '0;
      end else if (cmd.commit && fault) begin
         page_valid_ff[page_ff] <= 1'b1;
         next_frame_ff          <= next_frame_ff + NEXT_FRAME_W'(1);
      end
   end

   // TLB tags and frames: FIFO insert on every miss.
   always_ff @(posedge clock) begin
      if (cmd.commit && miss) begin
         for (int i = 0; i < TLB_ENTRIES; i++) begin
            if (tlb_full) begin
               if (i < TLB_ENTRIES - 1) begin
                  tlb_page_ff[i]  <= tlb_page_ff[i+1];
                  tlb_frame_ff[i] <= tlb_frame_ff[i+1];
               end else begin
                  tlb_page_ff[i]  <= page_ff;
                  tlb_frame_ff[i] <= frame_sel;
               end
            end else if (tlb_fill_ff == FILL_W'(i)) begin
               tlb_page_ff[i]  <= page_ff;
               tlb_frame_ff[i] <= frame_sel;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tlb_valid_ff <= '0;
         tlb_fill_ff  <= '0;
      end else if (cmd.commit && miss) begin
         for (int i = 0; i < TLB_ENTRIES; i++) begin
            if (tlb_full) begin
               if (i < TLB_ENTRIES - 1) begin
                  tlb_valid_ff[i] <= tlb_valid_ff[i+1];
               end else begin
                  tlb_valid_ff[i] <= 1'b1;
               end
            end else if (tlb_fill_ff == FILL_W'(i)) begin
               tlb_valid_ff[i] <= 1'b1;
            end
         end
         if (!tlb_full) begin
            tlb_fill_ff <= tlb_fill_ff + FILL_W'(1);
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_addr_ff  <= {frame_sel, offset_ff};
         rsp_hit_ff   <= hit_ff;
         rsp_fault_ff <= fault;
      end
   end

   assign status.rsp_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_phys_addr   = rsp_addr_ff;
   assign rsp_tlb_hit     = rsp_hit_ff;
   assign rsp_page_fault  = rsp_fault_ff;

endmodule

`default_nettype wire

// ----- sv/tlb_page_table_translator.sv -----
// Top level of the demand-paging address translator with a FIFO-replaced TLB.
// Instantiates tlbpt_ctrl and tlbpt_dp; depends on tlbpt_pkg.
//
// Usage: a 16-bit logical address arrives as one req_ beat (valid/ready). Its
// upper byte is the page and its lower byte the offset. Every request beat
// produces exactly one rsp_ beat carrying the physical address (frame * 256 +
// offset), a TLB hit flag and a page fault flag. A fault means the page had no
// frame yet; the next free frame has been assigned and the page should be loaded.
//
// Timing: a request is accepted into the request register, then passes a lookup
// state that compares the page against all TLB slots and reads the page table
// frame memory, whose read port is registered, and then a commit state that
// commits the page table and TLB updates and loads the result register. A new
// request can be accepted in the commit cycle, once the result register can take
// the beat, so a request can enter while the previous one commits.
//
// Reset clears the TLB valid bits and fill count, the page table valid bits
// and the free frame counter; frame memory contents need no clearing. If the
// receiver stalls, one finished result waits in the result register while the
// next request is looked up; that request then holds in its commit cycle, and
// no further request is taken until the result register frees.
`default_nettype none

module tlb_page_table_translator
   import tlbpt_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [ADDR_W-1:0] req_logical_address,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [ADDR_W-1:0]      rsp_phys_addr,
   output logic                   rsp_tlb_hit,
   output logic                   rsp_page_fault
);

   tlbpt_cmd_type    cmd;
   tlbpt_status_type status;

   tlbpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tlbpt_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_logical_address (req_logical_address),
      .rsp_ready           (rsp_ready),
      .rsp_valid           (rsp_valid),
      .rsp_phys_addr       (rsp_phys_addr),
      .rsp_tlb_hit         (rsp_tlb_hit),
      .rsp_page_fault      (rsp_page_fault)
   );

   // A translation cannot both hit in the TLB and fault.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_tlb_hit && rsp_page_fault))
      else $error("result flags both a TLB hit and a page fault");

   // The lookup cycle always follows an accepted beat, so no back-to-back accept.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted during the lookup cycle");

   // An accepted request reaches the result register after its lookup and commit.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> ##3 rsp_valid)
      else $error("accepted request produced no result");

endmodule

`default_nettype wire
